// File: sv/dpc_pkg.sv
// ----------------------------------------------------------------------------
// dpc_pkg
// Types, register indexes and constants of the dual PID position controller.
// ----------------------------------------------------------------------------
`default_nettype none

package dpc_pkg;

   localparam int FRAC_BITS      = 12;
   localparam int POS_WIDTH      = 16;
   localparam int GAIN_WIDTH     = 16;
   localparam int ERR_WIDTH      = 18;
   localparam int INTEG_WIDTH    = 40;
   localparam int DRIVE_WIDTH    = 8;
   localparam int CSR_IDX_WIDTH  = 3;
   localparam int CSR_DATA_WIDTH = 16;

   localparam logic signed [DRIVE_WIDTH-1:0] DRIVE_LIMIT = 8'sd100;

   localparam logic [GAIN_WIDTH-1:0] PROP_GAIN_RESET  = 16'd750;
   localparam logic [GAIN_WIDTH-1:0] INTEG_GAIN_RESET = 16'd61;
   localparam logic [GAIN_WIDTH-1:0] DERIV_GAIN_RESET = 16'd205;
   localparam logic [GAIN_WIDTH-1:0] ZONE_RESET       = 16'd1;
   localparam logic [GAIN_WIDTH-1:0] TOL_RESET        = 16'd10;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      REG_LEFT_TARGET    = 3'd0,
      REG_RIGHT_TARGET   = 3'd1,
      REG_PROP_GAIN      = 3'd2,
      REG_INTEG_GAIN     = 3'd3,
      REG_DERIV_GAIN     = 3'd4,
      REG_INTEGRAL_ZONE  = 3'd5,
      REG_DONE_TOLERANCE = 3'd6,
      REG_USE_MAGNITUDE  = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic signed [POS_WIDTH-1:0] left_position;
      logic signed [POS_WIDTH-1:0] right_position;
      logic                        restart;
   } dpc_req_type;

   typedef struct packed {
      logic signed [DRIVE_WIDTH-1:0] left_drive;
      logic signed [DRIVE_WIDTH-1:0] right_drive;
      logic                          move_done;
   } dpc_rsp_type;

   typedef struct packed {
      logic signed [POS_WIDTH-1:0] left_target;
      logic signed [POS_WIDTH-1:0] right_target;
      logic [GAIN_WIDTH-1:0]       prop_gain;
      logic [GAIN_WIDTH-1:0]       integ_gain;
      logic [GAIN_WIDTH-1:0]       deriv_gain;
      logic [GAIN_WIDTH-1:0]       integral_zone;
      logic [GAIN_WIDTH-1:0]       done_tolerance;
      logic                        use_magnitude;
   } dpc_cfg_type;

endpackage

`default_nettype wire

// File: sv/dpc_regs.sv
// ----------------------------------------------------------------------------
// dpc_regs
// Configuration register file: targets, gains, zone, tolerance, mode.
// ----------------------------------------------------------------------------
`default_nettype none

module dpc_regs (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_wr_en,
   input  wire logic [dpc_pkg::CSR_IDX_WIDTH-1:0]    csr_index,
   input  wire logic [dpc_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata,
   output dpc_pkg::dpc_cfg_type                      cfg
);
   import dpc_pkg::*;

   dpc_cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (reg_index_type'(csr_index))
            REG_LEFT_TARGET:    cfg_in.left_target    = $signed(csr_wdata);
            REG_RIGHT_TARGET:   cfg_in.right_target   = $signed(csr_wdata);
            REG_PROP_GAIN:      cfg_in.prop_gain      = csr_wdata;
            REG_INTEG_GAIN:     cfg_in.integ_gain     = csr_wdata;
            REG_DERIV_GAIN:     cfg_in.deriv_gain     = csr_wdata;
            REG_INTEGRAL_ZONE:  cfg_in.integral_zone  = csr_wdata;
            REG_DONE_TOLERANCE: cfg_in.done_tolerance = csr_wdata;
            REG_USE_MAGNITUDE:  cfg_in.use_magnitude  = csr_wdata[0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.left_target    <= '0;
         cfg_ff.right_target   <= '0;
         cfg_ff.prop_gain      <= PROP_GAIN_RESET;
         cfg_ff.integ_gain     <= INTEG_GAIN_RESET;
         cfg_ff.deriv_gain     <= DERIV_GAIN_RESET;
         cfg_ff.integral_zone  <= ZONE_RESET;
         cfg_ff.done_tolerance <= TOL_RESET;
         cfg_ff.use_magnitude  <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// File: sv/dpc_channel.sv
// ----------------------------------------------------------------------------
// dpc_channel
// One PID channel: integral update with saturation, P + I + D, truncation
// toward zero and clamp to +-100 percent.
// ----------------------------------------------------------------------------
`default_nettype none

module dpc_channel (
   input  wire logic signed [dpc_pkg::ERR_WIDTH-1:0]   err,
   input  wire logic signed [dpc_pkg::INTEG_WIDTH-1:0] integ,
   input  wire logic signed [dpc_pkg::ERR_WIDTH-1:0]   prev_err,
   input  wire logic [dpc_pkg::GAIN_WIDTH-1:0]         prop_gain,
   input  wire logic [dpc_pkg::GAIN_WIDTH-1:0]         integ_gain,
   input  wire logic [dpc_pkg::GAIN_WIDTH-1:0]         deriv_gain,
   output logic signed [dpc_pkg::INTEG_WIDTH-1:0]      integ_next,
   output logic signed [dpc_pkg::DRIVE_WIDTH-1:0]      drive
);
   import dpc_pkg::*;

   localparam int PROD_W  = GAIN_WIDTH + 1 + ERR_WIDTH;
   localparam int DIFF_W  = ERR_WIDTH + 1;
   localparam int DPROD_W = GAIN_WIDTH + 1 + DIFF_W;
   localparam int ISUM_W  = INTEG_WIDTH + 1;
   localparam int SUM_W   = INTEG_WIDTH + 2;
   localparam int Q_W     = SUM_W - FRAC_BITS;

   logic signed [GAIN_WIDTH:0]      kp_s, ki_s, kd_s;
   logic signed [DIFF_W-1:0]        diff;
   logic signed [PROD_W-1:0]        p_term, i_term;
   logic signed [DPROD_W-1:0]       d_term;
   logic signed [ISUM_W-1:0]        isum;
   logic signed [SUM_W-1:0]         total, total_adj;
   logic signed [Q_W-1:0]           q;

   always_comb begin
      kp_s   = $signed({1'b0, prop_gain});
      ki_s   = $signed({1'b0, integ_gain});
      kd_s   = $signed({1'b0, deriv_gain});
      diff   = DIFF_W'(err) - DIFF_W'(prev_err);
      p_term = kp_s * err;
      i_term = ki_s * err;
      d_term = kd_s * diff;

      isum = ISUM_W'(integ) + ISUM_W'(i_term);
      if (isum[ISUM_W-1] != isum[ISUM_W-2]) begin
         integ_next = isum[ISUM_W-1] ? {1'b1, {(INTEG_WIDTH-1){1'b0}}}
                                     : {1'b0, {(INTEG_WIDTH-1){1'b1}}};
      end else begin
         integ_next = isum[INTEG_WIDTH-1:0];
      end

      total = SUM_W'(integ_next) + SUM_W'(p_term) + SUM_W'(d_term);
      // round toward zero: bias negatives before the arithmetic shift
      total_adj = total[SUM_W-1] ? total + SUM_W'((1 << FRAC_BITS) - 1) : total;
      q = total_adj[SUM_W-1:FRAC_BITS];

      if (q > Q_W'(DRIVE_LIMIT)) begin
         drive = DRIVE_LIMIT;
      end else if (q < -Q_W'(DRIVE_LIMIT)) begin
         drive = -DRIVE_LIMIT;
      end else begin
         drive = q[DRIVE_WIDTH-1:0];
      end
   end

endmodule

`default_nettype wire

// File: sv/dual_pid_position_controller_core.sv
// ----------------------------------------------------------------------------
// dual_pid_position_controller_core
// Two-channel PID position controller with integral zone and latched done.
//
// Each request beat carries the left and right encoder positions and a
// restart flag; each produces exactly one response beat with both drives
// (percent, -100..100) and move_done.  Configuration is written through the
// csr_ port; the user must write it only while the block is idle, which the
// block itself does not enforce.  A request beat is captured into an input
// register; when the response register can take it, the PID arithmetic
// (three multiplies per channel, one sum, clamp) runs in one pass, updates
// the integrals, previous errors and done latch, and loads the response
// register.  Throughput is one beat per cycle while the receiver does not
// stall.  Reset clears the controller state, empties both registers and
// loads the default gains.  When the receiver stalls, the response holds,
// the input register fills and req_stall rises; no beat is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_pid_position_controller_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire dpc_pkg::dpc_req_type                req_payload,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output dpc_pkg::dpc_rsp_type                     rsp_payload,
   input  wire logic                                csr_wr_en,
   input  wire logic [dpc_pkg::CSR_IDX_WIDTH-1:0]   csr_index,
   input  wire logic [dpc_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);
   import dpc_pkg::*;

   localparam int MAG_W = ERR_WIDTH - 1;

   dpc_cfg_type cfg;

   logic        in_valid_ff, in_valid_in;
   dpc_req_type in_ff, in_in;
   logic        rsp_valid_ff, rsp_valid_in;
   dpc_rsp_type rsp_ff, rsp_in;

   logic signed [INTEG_WIDTH-1:0] l_integ_ff, l_integ_in, r_integ_ff, r_integ_in;
   logic signed [ERR_WIDTH-1:0]   l_prev_ff, l_prev_in, r_prev_ff, r_prev_in;
   logic                          done_ff, done_in;

   logic                          advance;
   logic signed [INTEG_WIDTH-1:0] l_integ_eff, r_integ_eff, l_integ_new, r_integ_new;
   logic signed [ERR_WIDTH-1:0]   l_prev_eff, r_prev_eff;
   logic                          done_eff;
   logic signed [MAG_W-1:0]       l_pos, r_pos;
   logic signed [ERR_WIDTH-1:0]   l_err, r_err, l_neg, r_neg;
   logic [MAG_W-1:0]              l_abs, r_abs;
   logic                          in_zone, hit;
   logic signed [DRIVE_WIDTH-1:0] l_drive, r_drive;

   dpc_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   always_comb begin
      l_pos = MAG_W'(in_ff.left_position);
      r_pos = MAG_W'(in_ff.right_position);
      if (cfg.use_magnitude) begin
         if (l_pos < 0) l_pos = -l_pos;
         if (r_pos < 0) r_pos = -r_pos;
      end
      // positions are magnitudes here when selected, so zero-extend then
      l_err = ERR_WIDTH'(cfg.left_target)
            - (cfg.use_magnitude ? $signed({1'b0, l_pos}) : ERR_WIDTH'(l_pos));
      r_err = ERR_WIDTH'(cfg.right_target)
            - (cfg.use_magnitude ? $signed({1'b0, r_pos}) : ERR_WIDTH'(r_pos));
      l_neg = -l_err;
      r_neg = -r_err;
      l_abs = l_err[ERR_WIDTH-1] ? l_neg[MAG_W-1:0] : l_err[MAG_W-1:0];
      r_abs = r_err[ERR_WIDTH-1] ? r_neg[MAG_W-1:0] : r_err[MAG_W-1:0];

      l_integ_eff = in_ff.restart ? '0 : l_integ_ff;
      r_integ_eff = in_ff.restart ? '0 : r_integ_ff;
      l_prev_eff  = in_ff.restart ? '0 : l_prev_ff;
      r_prev_eff  = in_ff.restart ? '0 : r_prev_ff;
      done_eff    = in_ff.restart ? 1'b0 : done_ff;

      in_zone = (l_abs < MAG_W'(cfg.integral_zone)) || (r_abs < MAG_W'(cfg.integral_zone));
      hit     = (l_abs < MAG_W'(cfg.done_tolerance)) || (r_abs < MAG_W'(cfg.done_tolerance));
   end

   dpc_channel u_left (
      .err        (l_err),
      .integ      (l_integ_eff),
      .prev_err   (l_prev_eff),
      .prop_gain  (cfg.prop_gain),
      .integ_gain (cfg.integ_gain),
      .deriv_gain (cfg.deriv_gain),
      .integ_next (l_integ_new),
      .drive      (l_drive)
   );

   dpc_channel u_right (
      .err        (r_err),
      .integ      (r_integ_eff),
      .prev_err   (r_prev_eff),
      .prop_gain  (cfg.prop_gain),
      .integ_gain (cfg.integ_gain),
      .deriv_gain (cfg.deriv_gain),
      .integ_next (r_integ_new),
      .drive      (r_drive)
   );

   always_comb begin
      advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
      req_stall = in_valid_ff && !advance;

      in_valid_in = req_stall ? in_valid_ff : req_valid;
      in_in       = (req_valid && !req_stall) ? req_payload : in_ff;

      rsp_valid_in = advance ? 1'b1 : (rsp_valid_ff && rsp_stall);
      rsp_in       = rsp_ff;

      l_integ_in = l_integ_ff;
      r_integ_in = r_integ_ff;
      l_prev_in  = l_prev_ff;
      r_prev_in  = r_prev_ff;
      done_in    = done_ff;

      if (advance) begin
         if (done_eff) begin
            rsp_in.left_drive  = '0;
            rsp_in.right_drive = '0;
            rsp_in.move_done   = 1'b1;
         end else begin
            l_integ_in = in_zone ? l_integ_new : '0;
            r_integ_in = in_zone ? r_integ_new : '0;
            l_prev_in  = l_err;
            r_prev_in  = r_err;
            done_in    = hit;
            rsp_in.left_drive  = hit ? '0 : l_drive;
            rsp_in.right_drive = hit ? '0 : r_drive;
            rsp_in.move_done   = hit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         l_integ_ff   <= '0;
         r_integ_ff   <= '0;
         l_prev_ff    <= '0;
         r_prev_ff    <= '0;
         done_ff      <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         l_integ_ff   <= l_integ_in;
         r_integ_ff   <= r_integ_in;
         l_prev_ff    <= l_prev_in;
         r_prev_ff    <= r_prev_in;
         done_ff      <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ff  <= in_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

// File: sv/dpc_checker.sv
// ----------------------------------------------------------------------------
// dpc_checker
// Port-level checks of the dual PID position controller, bound to the core.
// ----------------------------------------------------------------------------
`default_nettype none

module dpc_checker (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   input  wire dpc_pkg::dpc_rsp_type  rsp_payload
);
   import dpc_pkg::*;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_done_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.move_done |->
         rsp_payload.left_drive == '0 && rsp_payload.right_drive == '0)
      else $error("drives not zero on done");

   a_drive_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.left_drive <= DRIVE_LIMIT
                 && rsp_payload.left_drive >= -DRIVE_LIMIT
                 && rsp_payload.right_drive <= DRIVE_LIMIT
                 && rsp_payload.right_drive >= -DRIVE_LIMIT)
      else $error("drive out of range");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response changed");

endmodule

bind dual_pid_position_controller_core dpc_checker u_dpc_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

`default_nettype wire

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the dual PID position controller core.
//
// A directed table exercises reset defaults, drive clamping at the extremes
// of position, the done tick and latched done, restart, magnitude mode,
// zero zone and tolerance, and zero and full-scale gains.  Randomised phases
// follow, each under its own register setting.  They are mostly converging
// moves with random content, plus noise, and one phase drives both
// integrals into saturation.  Every request beat is run through a local
// model of both PID channels.  Response beats are checked field by field,
// in order, with random gaps on the request side and random stalls on the
// response side.
// ----------------------------------------------------------------------------

module testbench;

   timeunit 1ns;
   timeprecision 1ps;

   import dpc_pkg::*;

   localparam realtime HALF_PERIOD   = 1ns;
   localparam int      RESET_CYCLES  = 10;
   localparam int      SETTLE_CYCLES = 20;
   localparam int      QUIET_LIMIT   = 5000;
   localparam int      PHASES        = 9;
   localparam int      PHASE_BEATS   = 160;
   localparam int      SAT_BEATS     = 140;
   localparam int      POS_MIN       = -32768;
   localparam int      POS_MAX       = 32767;
   localparam longint INTEG_HI      = (longint'(1) <<< (INTEG_WIDTH - 1)) - 1;
   localparam longint INTEG_LO      = -INTEG_HI - 1;

   typedef enum logic {ROW_BEAT, ROW_CSR} row_kind_type;
   typedef enum logic {STYLE_TRACK, STYLE_SATURATE} phase_style_type;

   typedef struct {
      row_kind_type  kind;
      reg_index_type idx;
      logic [CSR_DATA_WIDTH-1:0] wdata;
      dpc_req_type   beat;
      bit            typed;
      dpc_rsp_type   want;
   } stim_row_type;

   logic                      clock       = 1'b0;
   logic                      reset       = 1'b1;
   logic                      req_valid   = 1'b0;
   logic                      req_stall;
   dpc_req_type               req_payload = '0;
   logic                      rsp_valid;
   logic                      rsp_stall   = 1'b0;
   dpc_rsp_type               rsp_payload;
   logic                      csr_wr_en   = 1'b0;
   logic [CSR_IDX_WIDTH-1:0]  csr_index   = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_wdata   = '0;

   dual_pid_position_controller_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // controller model: registers and per-channel state, index 0 left, 1 right
   dpc_cfg_type  cfg_model;
   longint       integ_sum [2];
   longint       last_err [2];
   bit           latched;

   dpc_rsp_type  expected_drives [$];
   stim_row_type directed_rows [$];
   int           failures     = 0;
   int           quiet_cycles = 0;
   int           stall_hold   = 0;

   function automatic longint clamp_integral(longint x);
      if (x > INTEG_HI) return INTEG_HI;
      if (x < INTEG_LO) return INTEG_LO;
      return x;
   endfunction

   function automatic longint pid_channel(int ch, longint err);
      longint s;
      longint q;
      integ_sum[ch] = clamp_integral(integ_sum[ch] + longint'(cfg_model.integ_gain) * err);
      s = longint'(cfg_model.prop_gain) * err + integ_sum[ch]
          + longint'(cfg_model.deriv_gain) * (err - last_err[ch]);
      q = s / (longint'(1) <<< FRAC_BITS);
      if (q > longint'(DRIVE_LIMIT)) q = longint'(DRIVE_LIMIT);
      if (q < -longint'(DRIVE_LIMIT)) q = -longint'(DRIVE_LIMIT);
      last_err[ch] = err;
      return q;
   endfunction

   function automatic dpc_rsp_type control_tick(dpc_req_type beat);
      longint      pos [2];
      longint      aim [2];
      longint      err [2];
      longint      drv [2];
      longint      mag [2];
      dpc_rsp_type res;
      if (beat.restart) begin
         integ_sum = '{0, 0};
         last_err  = '{0, 0};
         latched   = 1'b0;
      end
      if (latched) begin
         res.left_drive  = '0;
         res.right_drive = '0;
         res.move_done   = 1'b1;
         return res;
      end
      pos[0] = longint'(beat.left_position);
      pos[1] = longint'(beat.right_position);
      aim[0] = longint'(cfg_model.left_target);
      aim[1] = longint'(cfg_model.right_target);
      for (int ch = 0; ch < 2; ch++) begin
         if (cfg_model.use_magnitude && pos[ch] < 0) pos[ch] = -pos[ch];
         err[ch] = aim[ch] - pos[ch];
         drv[ch] = pid_channel(ch, err[ch]);
         mag[ch] = (err[ch] < 0) ? -err[ch] : err[ch];
      end
      if (!(mag[0] < longint'(cfg_model.integral_zone) ||
            mag[1] < longint'(cfg_model.integral_zone)))
         integ_sum = '{0, 0};
      if (mag[0] < longint'(cfg_model.done_tolerance) ||
          mag[1] < longint'(cfg_model.done_tolerance)) begin
         latched = 1'b1;
         drv     = '{0, 0};
      end
      res.left_drive  = DRIVE_WIDTH'(drv[0]);
      res.right_drive = DRIVE_WIDTH'(drv[1]);
      res.move_done   = latched;
      return res;
   endfunction

   // mostly back to back, some short gaps, a few long ones
   function automatic int idle_span();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic int rand_position();
      case ($urandom_range(0, 11))
         0:       return POS_MIN;
         1:       return POS_MAX;
         2:       return 0;
         3:       return -1;
         default: return int'($signed(POS_WIDTH'($urandom)));
      endcase
   endfunction

   function automatic int approach(int cur, int aim);
      int nxt;
      nxt = cur + (aim - cur) / int'($urandom_range(2, 5)) + int'($urandom_range(0, 16)) - 8;
      if (nxt > POS_MAX) nxt = POS_MAX;
      if (nxt < POS_MIN) nxt = POS_MIN;
      return nxt;
   endfunction

   function automatic stim_row_type beat_row(int lp, int rp, bit rs, bit typed = 1'b0,
                                             int wl = 0, int wr = 0, bit wd = 1'b0);
      stim_row_type row;
      row.kind                = ROW_BEAT;
      row.idx                 = REG_LEFT_TARGET;
      row.wdata               = '0;
      row.beat.left_position  = POS_WIDTH'(lp);
      row.beat.right_position = POS_WIDTH'(rp);
      row.beat.restart        = rs;
      row.typed               = typed;
      row.want.left_drive     = DRIVE_WIDTH'(wl);
      row.want.right_drive    = DRIVE_WIDTH'(wr);
      row.want.move_done      = wd;
      return row;
   endfunction

   function automatic stim_row_type csr_row(reg_index_type idx, int v);
      stim_row_type row;
      row       = beat_row(0, 0, 1'b0);
      row.kind  = ROW_CSR;
      row.idx   = idx;
      row.wdata = CSR_DATA_WIDTH'(v);
      return row;
   endfunction

   task automatic send_beat(dpc_req_type beat, bit typed, dpc_rsp_type want);
      int          gap;
      dpc_rsp_type predicted;
      gap = idle_span();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= beat;
      do @(posedge clock); while (req_stall !== 1'b0);
      predicted = control_tick(beat);
      expected_drives.push_back(typed ? want : predicted);
   endtask

   task automatic wait_settled();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_drives.size() != 0);
   endtask

   task automatic write_csr(reg_index_type idx, logic [CSR_DATA_WIDTH-1:0] v);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         REG_LEFT_TARGET:    cfg_model.left_target    = v;
         REG_RIGHT_TARGET:   cfg_model.right_target   = v;
         REG_PROP_GAIN:      cfg_model.prop_gain      = v;
         REG_INTEG_GAIN:     cfg_model.integ_gain     = v;
         REG_DERIV_GAIN:     cfg_model.deriv_gain     = v;
         REG_INTEGRAL_ZONE:  cfg_model.integral_zone  = v;
         REG_DONE_TOLERANCE: cfg_model.done_tolerance = v;
         REG_USE_MAGNITUDE:  cfg_model.use_magnitude  = v[0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic apply_cfg(dpc_cfg_type c);
      wait_settled();
      write_csr(REG_LEFT_TARGET, c.left_target);
      write_csr(REG_RIGHT_TARGET, c.right_target);
      write_csr(REG_PROP_GAIN, c.prop_gain);
      write_csr(REG_INTEG_GAIN, c.integ_gain);
      write_csr(REG_DERIV_GAIN, c.deriv_gain);
      write_csr(REG_INTEGRAL_ZONE, c.integral_zone);
      write_csr(REG_DONE_TOLERANCE, c.done_tolerance);
      write_csr(REG_USE_MAGNITUDE, CSR_DATA_WIDTH'(c.use_magnitude));
   endtask

   // moves: optional restart, random start, then converge or stay random
   task automatic run_phase(phase_style_type style, int n);
      int          lp;
      int          rp;
      int          aim_l;
      int          aim_r;
      int          beats_left;
      bit          noisy;
      bit          rs;
      dpc_req_type beat;
      dpc_rsp_type unused;
      lp         = 0;
      rp         = 0;
      aim_l      = 0;
      aim_r      = 0;
      beats_left = 0;
      noisy      = 1'b0;
      unused     = '0;
      for (int i = 0; i < n; i++) begin
         if (i == n / 2) wait_settled();
         rs = 1'b0;
         if (style == STYLE_SATURATE && i < SAT_BEATS) begin
            // one step inside the full-scale zone so the integrals are kept
            lp = POS_MIN + 1;
            rp = POS_MAX - 1;
            rs = (i == 0);
         end else if (beats_left == 0) begin
            beats_left = $urandom_range(4, 40);
            noisy      = ($urandom_range(0, 4) == 0);
            rs         = ($urandom_range(0, 9) != 0);
            lp         = rand_position();
            rp         = rand_position();
            aim_l      = int'(cfg_model.left_target);
            aim_r      = int'(cfg_model.right_target);
            if (cfg_model.use_magnitude && $urandom_range(0, 1)) aim_l = -aim_l;
            if (cfg_model.use_magnitude && $urandom_range(0, 1)) aim_r = -aim_r;
         end else if (noisy) begin
            lp = rand_position();
            rp = rand_position();
            rs = ($urandom_range(0, 15) == 0);
         end else begin
            lp = approach(lp, aim_l);
            rp = approach(rp, aim_r);
         end
         if (beats_left != 0) beats_left--;
         beat.left_position  = POS_WIDTH'(lp);
         beat.right_position = POS_WIDTH'(rp);
         beat.restart        = rs;
         send_beat(beat, 1'b0, unused);
      end
   endtask

   always @(posedge clock) begin : stall_gen
      int span;
      if (stall_hold != 0) begin
         stall_hold <= stall_hold - 1;
      end else if (rsp_stall) begin
         rsp_stall  <= 1'b0;
         stall_hold <= $urandom_range(0, 30);
      end else begin
         span       = idle_span();
         rsp_stall  <= (span != 0);
         stall_hold <= (span != 0) ? span - 1 : 0;
      end
   end

   always @(posedge clock) begin : rsp_check
      dpc_rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_drives.size() == 0) begin
            $error("unexpected response beat: %p", rsp_payload);
            failures++;
         end else begin
            want = expected_drives.pop_front();
            if (rsp_payload.left_drive !== want.left_drive) begin
               $error("left_drive: expected %0d, got %0d", want.left_drive,
                      rsp_payload.left_drive);
               failures++;
            end
            if (rsp_payload.right_drive !== want.right_drive) begin
               $error("right_drive: expected %0d, got %0d", want.right_drive,
                      rsp_payload.right_drive);
               failures++;
            end
            if (rsp_payload.move_done !== want.move_done) begin
               $error("move_done: expected %0d, got %0d", want.move_done,
                      rsp_payload.move_done);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid === 1'b1 && req_stall === 1'b0) ||
          (rsp_valid === 1'b1 && rsp_stall === 1'b0) || csr_wr_en) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      dpc_cfg_type c;

      cfg_model.left_target    = '0;
      cfg_model.right_target   = '0;
      cfg_model.prop_gain      = PROP_GAIN_RESET;
      cfg_model.integ_gain     = INTEG_GAIN_RESET;
      cfg_model.deriv_gain     = DERIV_GAIN_RESET;
      cfg_model.integral_zone  = ZONE_RESET;
      cfg_model.done_tolerance = TOL_RESET;
      cfg_model.use_magnitude  = 1'b0;
      integ_sum = '{0, 0};
      last_err  = '{0, 0};
      latched   = 1'b0;

      // reset defaults: targets 0, tolerance 10, zone 1
      directed_rows.push_back(beat_row(0, 0, 1'b0, 1'b1, 0, 0, 1'b1));
      directed_rows.push_back(beat_row(5000, -5000, 1'b0, 1'b1, 0, 0, 1'b1));
      directed_rows.push_back(beat_row(1000, 1000, 1'b1, 1'b1, -100, -100, 1'b0));
      directed_rows.push_back(beat_row(POS_MIN, POS_MIN, 1'b1, 1'b1, 100, 100, 1'b0));
      directed_rows.push_back(beat_row(POS_MAX, POS_MIN, 1'b1, 1'b1, -100, 100, 1'b0));
      directed_rows.push_back(beat_row(POS_MIN, POS_MAX, 1'b0));
      directed_rows.push_back(beat_row(5, 100, 1'b0, 1'b1, 0, 0, 1'b1));
      directed_rows.push_back(beat_row(0, 0, 1'b0, 1'b1, 0, 0, 1'b1));
      // magnitude mode, most negative position
      directed_rows.push_back(csr_row(REG_USE_MAGNITUDE, 1));
      directed_rows.push_back(beat_row(POS_MIN, POS_MIN, 1'b1, 1'b1, -100, -100, 1'b0));
      directed_rows.push_back(beat_row(-3, 200, 1'b0, 1'b1, 0, 0, 1'b1));
      directed_rows.push_back(csr_row(REG_LEFT_TARGET, 200));
      directed_rows.push_back(csr_row(REG_RIGHT_TARGET, -200));
      directed_rows.push_back(csr_row(REG_USE_MAGNITUDE, 0));
      directed_rows.push_back(beat_row(150, -150, 1'b1));
      directed_rows.push_back(beat_row(180, -190, 1'b0));
      directed_rows.push_back(beat_row(190, -195, 1'b0));
      // zero zone and tolerance: never done, integrals always cleared
      directed_rows.push_back(csr_row(REG_INTEGRAL_ZONE, 0));
      directed_rows.push_back(csr_row(REG_DONE_TOLERANCE, 0));
      directed_rows.push_back(beat_row(200, -200, 1'b1, 1'b1, 0, 0, 1'b0));
      directed_rows.push_back(beat_row(POS_MAX, POS_MIN, 1'b0));
      directed_rows.push_back(csr_row(REG_PROP_GAIN, 0));
      directed_rows.push_back(csr_row(REG_INTEG_GAIN, 0));
      directed_rows.push_back(csr_row(REG_DERIV_GAIN, 0));
      directed_rows.push_back(beat_row(POS_MIN, POS_MAX, 1'b1, 1'b1, 0, 0, 1'b0));
      // full-scale gains, zone and tolerance
      directed_rows.push_back(csr_row(REG_PROP_GAIN, 65535));
      directed_rows.push_back(csr_row(REG_INTEG_GAIN, 65535));
      directed_rows.push_back(csr_row(REG_DERIV_GAIN, 65535));
      directed_rows.push_back(csr_row(REG_INTEGRAL_ZONE, 65535));
      directed_rows.push_back(csr_row(REG_DONE_TOLERANCE, 65535));
      directed_rows.push_back(beat_row(0, 0, 1'b1, 1'b1, 0, 0, 1'b1));
      directed_rows.push_back(csr_row(REG_DONE_TOLERANCE, 0));
      directed_rows.push_back(beat_row(POS_MIN, POS_MAX, 1'b1));
      directed_rows.push_back(beat_row(POS_MAX, POS_MIN, 1'b0));

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            wait_settled();
            write_csr(directed_rows[i].idx, directed_rows[i].wdata);
         end else begin
            send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want);
         end
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         c.left_target    = POS_WIDTH'(rand_position());
         c.right_target   = POS_WIDTH'(rand_position());
         c.prop_gain      = GAIN_WIDTH'($urandom_range(0, 4095));
         c.integ_gain     = GAIN_WIDTH'($urandom_range(0, 1023));
         c.deriv_gain     = GAIN_WIDTH'($urandom_range(0, 2047));
         c.integral_zone  = GAIN_WIDTH'($urandom_range(0, 3000));
         c.done_tolerance = GAIN_WIDTH'($urandom_range(0, 60));
         c.use_magnitude  = 1'($urandom_range(0, 1));
         case (ph)
            0: begin
               c.prop_gain      = PROP_GAIN_RESET;
               c.integ_gain     = INTEG_GAIN_RESET;
               c.deriv_gain     = DERIV_GAIN_RESET;
               c.integral_zone  = ZONE_RESET;
               c.done_tolerance = TOL_RESET;
               c.use_magnitude  = 1'b0;
            end
            2: begin
               // far targets, full gains: both integrals run into saturation
               c.left_target    = POS_WIDTH'(POS_MAX);
               c.right_target   = POS_WIDTH'(POS_MIN);
               c.prop_gain      = '1;
               c.integ_gain     = '1;
               c.deriv_gain     = '1;
               c.integral_zone  = '1;
               c.done_tolerance = '0;
               c.use_magnitude  = 1'b0;
            end
            3: begin
               c.integral_zone  = '0;
               c.done_tolerance = '0;
            end
            4: begin
               c.prop_gain      = GAIN_WIDTH'($urandom);
               c.integ_gain     = GAIN_WIDTH'($urandom);
               c.deriv_gain     = GAIN_WIDTH'($urandom);
               c.integral_zone  = GAIN_WIDTH'($urandom);
               c.done_tolerance = $urandom_range(0, 1) ? '0 : GAIN_WIDTH'($urandom_range(0, 200));
            end
            5: c.use_magnitude = 1'b1;
            6: begin
               c.prop_gain  = '0;
               c.integ_gain = '0;
               c.deriv_gain = '0;
            end
            default: ;
         endcase
         apply_cfg(c);
         run_phase((ph == 2) ? STYLE_SATURATE : STYLE_TRACK, PHASE_BEATS);
      end

      wait_settled();
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      if (failures == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
